// ===== sv/utu_pkg.sv =====
// ----------------------------------------------------------------------------
// utu_pkg
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package utu_pkg;

  localparam int BUDGET_BITS_DEFAULT = 32;
  localparam int BUDGET_IN_BITS      = 32;
  localparam int COUNT_BITS          = 32;
  localparam int MAX_BYTES           = 4;

  // error codes
  localparam logic [1:0] ERR_NONE          = 2'd0;
  localparam logic [1:0] ERR_UNPAIRED_HIGH = 2'd1;
  localparam logic [1:0] ERR_LONE_LOW      = 2'd2;
  localparam logic [1:0] ERR_BUDGET        = 2'd3;

  // surrogate ranges, 6-bit prefix of the code unit
  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;  // 0xDC00..0xDFFF

  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [20:0] LIM_1B    = 21'h7f;
  localparam logic [20:0] LIM_2B    = 21'h7ff;
  localparam logic [20:0] LIM_3B    = 21'hffff;

  localparam logic [7:0] LEAD_2B = 8'hc0;
  localparam logic [7:0] LEAD_3B = 8'he0;
  localparam logic [7:0] LEAD_4B = 8'hf0;
  localparam logic [7:0] CONT_B  = 8'h80;

  typedef struct packed {
    logic [9:0]            pending_high;
    logic                  have_pending;
    logic                  dropping;
    logic                  at_string_start;
    logic [COUNT_BITS-1:0] bytes_emitted;
  } utu_state_t;

  // bytes for one code unit, byte 0 goes out first
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      eos;
    logic [1:0]                err;
  } utu_group_t;

endpackage

// ===== sv/utu_encode.sv =====
// ----------------------------------------------------------------------------
// utu_encode
// Per-unit decode: surrogate pairing, UTF-8 byte build, budget check and
// next string state.
// ----------------------------------------------------------------------------
module utu_encode #(
  parameter int BUDGET_BITS = utu_pkg::BUDGET_BITS_DEFAULT
) (
  input  logic [15:0]                        code_unit,
  input  logic                               last_unit,
  input  logic [utu_pkg::BUDGET_IN_BITS-1:0] byte_budget,
  input  utu_pkg::utu_state_t                st,
  input  logic [BUDGET_BITS-1:0]             budget_held,
  output utu_pkg::utu_state_t                st_next,
  output logic [BUDGET_BITS-1:0]             budget_held_next,
  output utu_pkg::utu_group_t                grp
);

  localparam int EXT_W = (BUDGET_BITS > utu_pkg::BUDGET_IN_BITS) ?
                         BUDGET_BITS : utu_pkg::BUDGET_IN_BITS;
  localparam int CMP_W = (BUDGET_BITS > utu_pkg::COUNT_BITS + 2) ?
                         BUDGET_BITS : utu_pkg::COUNT_BITS + 2;
  localparam logic [EXT_W-1:0] BUDGET_SAT = EXT_W'({BUDGET_BITS{1'b1}});

  logic [EXT_W-1:0]                budget_ext;
  logic [BUDGET_BITS-1:0]          budget_eff;
  logic [utu_pkg::COUNT_BITS-1:0]  bytes_eff;
  logic                            pending_eff;
  logic                            dropping_eff;
  logic                            is_high;
  logic                            is_low;
  logic [20:0]                     scalar;
  logic [utu_pkg::MAX_BYTES-1:0][7:0] enc;
  logic [2:0]                      enc_n;
  logic [CMP_W-1:0]                sum;
  logic                            over;
  logic                            fault;
  logic [1:0]                      fault_code;
  logic                            emit;

  // budget sampled on the first unit, saturated to the held width
  assign budget_ext = EXT_W'(byte_budget);
  assign budget_eff = st.at_string_start ?
                      BUDGET_BITS'((budget_ext > BUDGET_SAT) ? BUDGET_SAT : budget_ext) :
                      budget_held;
  assign bytes_eff    = st.at_string_start ? '0 : st.bytes_emitted;
  assign pending_eff  = st.at_string_start ? 1'b0 : st.have_pending;
  assign dropping_eff = st.at_string_start ? 1'b0 : st.dropping;

  assign is_high = (code_unit[15:10] == utu_pkg::HIGH_SURR_TAG);
  assign is_low  = (code_unit[15:10] == utu_pkg::LOW_SURR_TAG);

  assign scalar = pending_eff ?
                  (utu_pkg::SUPP_BASE + {1'b0, st.pending_high, code_unit[9:0]}) :
                  {5'd0, code_unit};

  always_comb begin
    enc = '0;
    if (scalar <= utu_pkg::LIM_1B) begin
      enc[0] = scalar[7:0];
      enc_n  = 3'd1;
    end else if (scalar <= utu_pkg::LIM_2B) begin
      enc[0] = utu_pkg::LEAD_2B | {3'd0, scalar[10:6]};
      enc[1] = utu_pkg::CONT_B | {2'd0, scalar[5:0]};
      enc_n  = 3'd2;
    end else if (scalar <= utu_pkg::LIM_3B) begin
      enc[0] = utu_pkg::LEAD_3B | {4'd0, scalar[15:12]};
      enc[1] = utu_pkg::CONT_B | {2'd0, scalar[11:6]};
      enc[2] = utu_pkg::CONT_B | {2'd0, scalar[5:0]};
      enc_n  = 3'd3;
    end else begin
      enc[0] = utu_pkg::LEAD_4B | {5'd0, scalar[20:18]};
      enc[1] = utu_pkg::CONT_B | {2'd0, scalar[17:12]};
      enc[2] = utu_pkg::CONT_B | {2'd0, scalar[11:6]};
      enc[3] = utu_pkg::CONT_B | {2'd0, scalar[5:0]};
      enc_n  = 3'd4;
    end
  end

  assign sum  = CMP_W'(bytes_eff) + CMP_W'(enc_n);
  assign over = sum > CMP_W'(budget_eff);

  always_comb begin
    fault      = 1'b0;
    fault_code = utu_pkg::ERR_NONE;
    emit       = 1'b0;
    st_next    = st;
    st_next.at_string_start = 1'b0;
    st_next.have_pending    = pending_eff;
    st_next.dropping        = dropping_eff;
    st_next.bytes_emitted   = bytes_eff;

    if (dropping_eff) begin
      st_next.dropping        = !last_unit;
      st_next.at_string_start = last_unit;
    end else if (pending_eff && !is_low) begin
      fault      = 1'b1;
      fault_code = utu_pkg::ERR_UNPAIRED_HIGH;
    end else if (!pending_eff && is_high) begin
      if (last_unit) begin
        fault      = 1'b1;
        fault_code = utu_pkg::ERR_UNPAIRED_HIGH;
      end else begin
        st_next.pending_high = code_unit[9:0];
        st_next.have_pending = 1'b1;
      end
    end else if (!pending_eff && is_low) begin
      fault      = 1'b1;
      fault_code = utu_pkg::ERR_LONE_LOW;
    end else if (over) begin
      fault      = 1'b1;
      fault_code = utu_pkg::ERR_BUDGET;
    end else begin
      emit                    = 1'b1;
      st_next.have_pending    = 1'b0;
      st_next.bytes_emitted   = sum[utu_pkg::COUNT_BITS-1:0];
      st_next.at_string_start = last_unit;
    end

    if (fault) begin
      st_next.have_pending    = 1'b0;
      st_next.dropping        = !last_unit;
      st_next.at_string_start = last_unit;
    end
  end

  assign budget_held_next = budget_eff;

  always_comb begin
    grp       = '0;
    grp.eos   = last_unit;
    if (fault) begin
      grp.count = 3'd1;
      grp.eos   = 1'b1;
      grp.err   = fault_code;
    end else if (emit) begin
      grp.bytes = enc;
      grp.count = enc_n;
    end
  end

endmodule

// ===== sv/utu_out_buf.sv =====
// ----------------------------------------------------------------------------
// utu_out_buf
// Result register: holds the bytes of one unit and sends them one word
// per cycle while byte_stall is low. It can reload in the cycle its final word is taken.
// ----------------------------------------------------------------------------
module utu_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  utu_pkg::utu_group_t grp,
  output logic                can_load,
  output logic                byte_valid,
  input  logic                byte_stall,
  output logic [7:0]          out_byte,
  output logic                last_of_run,
  output logic                end_of_string,
  output logic [1:0]          err_code
);

  logic [utu_pkg::MAX_BYTES-1:0][7:0] bytes;
  logic [2:0]                         remain;
  logic [2:0]                         remain_next;
  logic                               eos;
  logic [1:0]                         err;
  logic                               pop;

  assign byte_valid = (remain != 3'd0);
  assign pop        = byte_valid && !byte_stall;
  assign can_load   = (remain == 3'd0) || (remain == 3'd1 && !byte_stall);

  always_comb begin
    remain_next = remain;
    if (load) begin
      remain_next = grp.count;
    end else if (pop) begin
      remain_next = remain - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= 3'd0;
    end else begin
      remain <= remain_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= grp.bytes;
      eos   <= grp.eos;
      err   <= grp.err;
    end else if (pop) begin
      bytes <= {8'd0, bytes[utu_pkg::MAX_BYTES-1:1]};
    end
  end

  assign out_byte      = bytes[0];
  assign last_of_run   = (remain == 3'd1);
  assign end_of_string = last_of_run && eos;
  assign err_code      = err;

  a_remain_range: assert property (@(posedge clk) disable iff (rst)
    remain <= 3'(utu_pkg::MAX_BYTES))
    else $error("byte count out of range");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    byte_valid && err_code != utu_pkg::ERR_NONE |-> last_of_run && end_of_string &&
    out_byte == 8'd0)
    else $error("error result not a single zero word");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    pop && last_of_run && !load |=> !byte_valid)
    else $error("buffer not empty after final word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(remain))
    else $error("pending words lost while stalled");

endmodule

// ===== sv/utf16_to_utf8_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Streaming UTF-16 to UTF-8 conversion with surrogate pairing, per-string
// byte budget and error reporting.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  unit    | unit_valid / unit_stall | code_unit, last_unit, byte_budget
//  byte    | byte_valid / byte_stall | out_byte, last_of_run, end_of_string,
//          |                         | err_code
//
//  A unit is decoded in the cycle it is accepted and lands in the result
//  register; its words leave one per cycle while byte_stall is low, as many as its
//  UTF-8 length, or one zero word on an error. A unit with no bytes loads none.
//  The next unit is taken in the cycle the previous unit's final word leaves.
//  Reset (rst, synchronous) empties the result register and starts a new string.
//  byte_stall holds the current word; unit_stall rises while more than one
//  word remains or the final word is stalled.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder #(
  parameter int BUDGET_BITS = utu_pkg::BUDGET_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               unit_valid,
  output logic                               unit_stall,
  input  logic [15:0]                        code_unit,
  input  logic                               last_unit,
  input  logic [utu_pkg::BUDGET_IN_BITS-1:0] byte_budget,
  output logic                               byte_valid,
  input  logic                               byte_stall,
  output logic [7:0]                         out_byte,
  output logic                               last_of_run,
  output logic                               end_of_string,
  output logic [1:0]                         err_code
);

  utu_pkg::utu_state_t    st;
  utu_pkg::utu_state_t    st_next;
  logic [BUDGET_BITS-1:0] budget_held;
  logic [BUDGET_BITS-1:0] budget_held_next;
  utu_pkg::utu_group_t    grp;
  logic                   can_load;
  logic                   take;

  assign unit_stall = !can_load;
  assign take       = unit_valid && can_load;

  utu_encode #(
    .BUDGET_BITS (BUDGET_BITS)
  ) u_encode (
    .code_unit        (code_unit),
    .last_unit        (last_unit),
    .byte_budget      (byte_budget),
    .st               (st),
    .budget_held      (budget_held),
    .st_next          (st_next),
    .budget_held_next (budget_held_next),
    .grp              (grp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= '{pending_high: '0, have_pending: 1'b0, dropping: 1'b0,
                       at_string_start: 1'b1, bytes_emitted: '0};
      budget_held <= '0;
    end else if (take) begin
      st          <= st_next;
      budget_held <= budget_held_next;
    end
  end

  utu_out_buf u_out_buf (
    .clk           (clk),
    .rst           (rst),
    .load          (take),
    .grp           (grp),
    .can_load      (can_load),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .end_of_string (end_of_string),
    .err_code      (err_code)
  );

  a_pending_clear: assert property (@(posedge clk) disable iff (rst)
    st.dropping |-> !st.have_pending)
    else $error("held surrogate while discarding");

  a_start_clean: assert property (@(posedge clk) disable iff (rst)
    take && last_unit |=> st.at_string_start && !st.dropping)
    else $error("string end not taken");

  a_budget: assert property (@(posedge clk) disable iff (rst)
    !st.at_string_start && BUDGET_BITS <= utu_pkg::COUNT_BITS |->
    st.bytes_emitted <= utu_pkg::COUNT_BITS'(budget_held))
    else $error("bytes over budget");

endmodule

// ===== dv/utf16_to_utf8_transcoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_tb
// Self-checking bench for the UTF-16 to UTF-8 transcoder. A directed set of
// strings hits the encoding boundaries, surrogate faults and budget limits.
// Random strings follow, mostly well formed with random budgets, plus noise.
// A cycle-free predictor builds the expected byte words. The run steps
// through four phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_tb;

  localparam int          BUDGET_W    = utu_pkg::BUDGET_BITS_DEFAULT;
  localparam logic [63:0] BUDGET_CEIL = (BUDGET_W >= 64) ? '1 : ((64'd1 << BUDGET_W) - 64'd1);
  localparam int          QUIET_LIMIT = 2000;
  localparam int          DRAIN_WAIT  = 8;

  typedef struct packed {
    logic [15:0] cu;
    logic        lu;
    logic [31:0] bud;
  } unit_word_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       run_end;
    logic       str_end;
    logic [1:0] err;
  } utf8_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        unit_valid = 1'b0;
  logic        unit_stall;
  logic [15:0] code_unit = '0;
  logic        last_unit = 1'b0;
  logic [31:0] byte_budget = '0;
  logic        byte_valid;
  logic        byte_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        end_of_string;
  logic [1:0]  err_code;

  unit_word_t unit_backlog[$];
  utf8_word_t utf8_expected[$];
  unit_word_t nxt_unit;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int units_queued = 0;
  int units_sent = 0;
  int words_seen = 0;
  int fault_words = 0;
  int failures = 0;
  int quiet_cycles = 0;

  // predictor state
  logic [9:0]  hi_half = '0;
  logic        hi_held = 1'b0;
  logic        skipping = 1'b0;
  logic        new_string = 1'b1;
  logic [63:0] bytes_out = '0;
  logic [63:0] budget_cap = '0;

  utf16_to_utf8_transcoder #(.BUDGET_BITS(BUDGET_W)) dut (
    .clk          (clk),
    .rst          (rst),
    .unit_valid   (unit_valid),
    .unit_stall   (unit_stall),
    .code_unit    (code_unit),
    .last_unit    (last_unit),
    .byte_budget  (byte_budget),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .end_of_string(end_of_string),
    .err_code     (err_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  task automatic push_fault(input logic [1:0] code, input logic lu);
    utf8_expected.push_back('{byte_val: 8'h00, run_end: 1'b1, str_end: 1'b1, err: code});
    hi_held = 1'b0;
    if (lu) begin
      new_string = 1'b1;
      skipping   = 1'b0;
    end else begin
      skipping = 1'b1;
    end
  endtask

  task automatic predict_unit(input unit_word_t u);
    logic [20:0] scalar;
    logic [7:0]  enc[4];
    int          n;
    if (new_string) begin
      budget_cap = (64'(u.bud) > BUDGET_CEIL) ? BUDGET_CEIL : 64'(u.bud);
      bytes_out  = '0;
      hi_held    = 1'b0;
      skipping   = 1'b0;
      new_string = 1'b0;
    end
    if (skipping) begin
      if (u.lu) begin
        skipping   = 1'b0;
        new_string = 1'b1;
      end
      return;
    end
    if (hi_held) begin
      // the unit after a high half is consumed even when it faults
      if (u.cu[15:10] != utu_pkg::LOW_SURR_TAG) begin
        push_fault(utu_pkg::ERR_UNPAIRED_HIGH, u.lu);
        return;
      end
      scalar  = utu_pkg::SUPP_BASE + {1'b0, hi_half, u.cu[9:0]};
      hi_held = 1'b0;
    end else if (u.cu[15:10] == utu_pkg::HIGH_SURR_TAG) begin
      if (u.lu) begin
        push_fault(utu_pkg::ERR_UNPAIRED_HIGH, u.lu);
        return;
      end
      hi_half = u.cu[9:0];
      hi_held = 1'b1;
      return;
    end else if (u.cu[15:10] == utu_pkg::LOW_SURR_TAG) begin
      push_fault(utu_pkg::ERR_LONE_LOW, u.lu);
      return;
    end else begin
      scalar = {5'd0, u.cu};
    end

    if (scalar <= utu_pkg::LIM_1B) begin
      enc[0] = scalar[7:0];
      n = 1;
    end else if (scalar <= utu_pkg::LIM_2B) begin
      enc[0] = utu_pkg::LEAD_2B | {3'd0, scalar[10:6]};
      enc[1] = utu_pkg::CONT_B | {2'd0, scalar[5:0]};
      n = 2;
    end else if (scalar <= utu_pkg::LIM_3B) begin
      enc[0] = utu_pkg::LEAD_3B | {4'd0, scalar[15:12]};
      enc[1] = utu_pkg::CONT_B | {2'd0, scalar[11:6]};
      enc[2] = utu_pkg::CONT_B | {2'd0, scalar[5:0]};
      n = 3;
    end else begin
      enc[0] = utu_pkg::LEAD_4B | {5'd0, scalar[20:18]};
      enc[1] = utu_pkg::CONT_B | {2'd0, scalar[17:12]};
      enc[2] = utu_pkg::CONT_B | {2'd0, scalar[11:6]};
      enc[3] = utu_pkg::CONT_B | {2'd0, scalar[5:0]};
      n = 4;
    end

    if (bytes_out > budget_cap || 64'(n) > budget_cap - bytes_out) begin
      push_fault(utu_pkg::ERR_BUDGET, u.lu);
      return;
    end
    bytes_out = (bytes_out + 64'(n)) & 64'hffff_ffff;
    for (int k = 0; k < n; k++)
      utf8_expected.push_back('{byte_val: enc[k], run_end: (k == n - 1),
                                str_end: (u.lu && k == n - 1), err: utu_pkg::ERR_NONE});
    if (u.lu)
      new_string = 1'b1;
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic add_unit(input logic [15:0] cu, input logic lu, input logic [31:0] bud);
    unit_backlog.push_back('{cu: cu, lu: lu, bud: bud});
    units_queued++;
  endtask

  task automatic add_random_string();
    logic [15:0] su[$];
    logic [15:0] v;
    logic [9:0]  r;
    logic [31:0] bud;
    int          len;
    int          utf8_len;
    int          pick;
    int          tight;
    len      = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 7);
    utf8_len = 0;
    if ($urandom_range(99) < 80) begin
      while (su.size() < len) begin
        r = 10'($urandom);
        case ($urandom_range(3))
          0: begin
            su.push_back(16'($urandom_range(0, 16'h7f)));
            utf8_len += 1;
          end
          1: begin
            su.push_back(16'($urandom_range(16'h80, 16'h7ff)));
            utf8_len += 2;
          end
          2: begin
            v = 16'($urandom_range(16'h800, 16'hffff));
            if (v[15:11] == 5'b11011)
              v[13] = ~v[13];   // move out of the surrogate block
            su.push_back(v);
            utf8_len += 3;
          end
          default: begin
            su.push_back({utu_pkg::HIGH_SURR_TAG, r});
            su.push_back({utu_pkg::LOW_SURR_TAG, 10'($urandom)});
            utf8_len += 4;
          end
        endcase
      end
    end else begin
      // noise: surrogate halves in arbitrary order mixed with anything
      for (int i = 0; i < len; i++) begin
        r = 10'($urandom);
        case ($urandom_range(3))
          0:       su.push_back(16'($urandom));
          1:       su.push_back({utu_pkg::HIGH_SURR_TAG, r});
          2:       su.push_back({utu_pkg::LOW_SURR_TAG, r});
          default: su.push_back(16'($urandom_range(0, 16'h7f)));
        endcase
      end
      utf8_len = 3 * len;
    end
    pick = $urandom_range(99);
    if (pick < 55) begin
      bud = $urandom;
    end else if (pick < 85) begin
      tight = utf8_len - $urandom_range(0, 2);
      bud   = (tight < 0) ? 32'd0 : 32'(tight);
    end else begin
      bud = 32'($urandom_range(0, 6));
    end
    // budget is only sampled on the first unit; the rest carry junk
    for (int i = 0; i < su.size(); i++)
      add_unit(su[i], i == su.size() - 1, (i == 0) ? bud : $urandom);
  endtask

  task automatic wait_drained();
    do
      @(negedge clk);
    while (unit_backlog.size() != 0 || unit_valid || utf8_expected.size() != 0);
    // units that give no word may still be in flight
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  initial begin
    int target;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single ASCII at the bottom of the range
    add_unit(16'h0000, 1'b1, 32'd1);
    // 1/2/3-byte boundaries around the surrogate block, widest budget
    add_unit(16'h007f, 1'b0, 32'hffff_ffff);
    add_unit(16'h0080, 1'b0, 32'h0);
    add_unit(16'h07ff, 1'b0, 32'h0);
    add_unit(16'h0800, 1'b0, 32'h0);
    add_unit(16'hd7ff, 1'b0, 32'h0);
    add_unit(16'he000, 1'b0, 32'h0);
    add_unit(16'hffff, 1'b1, 32'h0);
    // lowest and highest surrogate pairs, budget exactly fits both
    add_unit(16'hd800, 1'b0, 32'd8);
    add_unit(16'hdc00, 1'b0, 32'd0);
    add_unit(16'hdbff, 1'b0, 32'd0);
    add_unit(16'hdfff, 1'b1, 32'd0);
    // lone low half as the last unit
    add_unit(16'hdc00, 1'b1, 32'd100);
    // high half as the last unit
    add_unit(16'hd900, 1'b1, 32'd100);
    // high half then plain unit: fault, rest of string dropped
    add_unit(16'hd800, 1'b0, 32'd100);
    add_unit(16'h0041, 1'b0, 32'd100);
    add_unit(16'h0042, 1'b1, 32'd100);
    // high half then another high half on the last unit
    add_unit(16'hdbff, 1'b0, 32'd100);
    add_unit(16'hd800, 1'b1, 32'd100);
    // zero budget
    add_unit(16'h0041, 1'b1, 32'd0);
    // three bytes fit, the next unit overflows on the last unit
    add_unit(16'h0800, 1'b0, 32'd3);
    add_unit(16'h0041, 1'b1, 32'd3);
    // lone low half mid string, remainder dropped
    add_unit(16'hdc00, 1'b0, 32'd100);
    add_unit(16'h0041, 1'b1, 32'd100);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      target = units_queued + 56;
      while (units_queued < target)
        add_random_string();
      // sender holds off until every expected word is back
      wait_drained();
    end

    $display("run: %0d code units sent, %0d UTF-8 words checked, %0d of them fault words",
             units_sent, words_seen, fault_words);
    $display("run: directed boundaries plus random strings under four idle/stall mixes");
    if (failures == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      unit_valid <= 1'b0;
    end else begin
      if (unit_valid && !unit_stall) begin
        predict_unit('{cu: code_unit, lu: last_unit, bud: byte_budget});
        units_sent++;
      end
      if (!unit_valid || !unit_stall) begin
        if (unit_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt_unit = unit_backlog.pop_front();
          code_unit   <= nxt_unit.cu;
          last_unit   <= nxt_unit.lu;
          byte_budget <= nxt_unit.bud;
          unit_valid  <= 1'b1;
        end else begin
          unit_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    utf8_word_t exp_w;
    if (rst) begin
      byte_stall <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        words_seen++;
        if (err_code != utu_pkg::ERR_NONE)
          fault_words++;
        if (utf8_expected.size() == 0) begin
          $error("unexpected word: out_byte 0x%0h err_code %0d", out_byte, err_code);
          failures++;
        end else begin
          exp_w = utf8_expected.pop_front();
          check_field("out_byte", exp_w.byte_val, out_byte);
          check_field("last_of_run", exp_w.run_end, last_of_run);
          check_field("end_of_string", exp_w.str_end, end_of_string);
          check_field("err_code", exp_w.err, err_code);
        end
      end
      byte_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((unit_valid && !unit_stall) || (byte_valid && !byte_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d words outstanding",
                 QUIET_LIMIT, utf8_expected.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule
